/* src/hsl2rgb_pkg.sv */
// Package for the HSL to RGB pixel converter.
// Holds the fixed-point format constants, the stage payload types and the hue ramp function.
// It has no dependencies; every other file in src refers to it by scoped names.
package hsl2rgb_pkg;

  // Format of the pixel fields.
  localparam int HUE_BITS  = 12;
  localparam int FRAC_BITS = 8;

  // Saturation and lightness are Q1.FRAC_BITS, so one extra bit holds 1.0.
  localparam int SL_W = FRAC_BITS + 1;
  // Products of two Q1.F values, scaled by 2^(2F): the largest value is exactly 2^(2F).
  localparam int MS_W = 2 * FRAC_BITS + 1;
  // A position on the hue circle, in units of 1/(3*2^HUE_BITS) turn.
  localparam int X_W = HUE_BITS + 2;
  // The ramp weight runs from 0 to 2^HUE_BITS inclusive.
  localparam int T_W = HUE_BITS + 1;
  // The channel value before the scale by 255: at most m2 * 2^HUE_BITS.
  localparam int ACC_W = MS_W + HUE_BITS;
  // Shift that removes the fraction after the scale by 255.
  localparam int OUT_SHIFT = 2 * FRAC_BITS + HUE_BITS;
  localparam int CH_W = 8;

  // Stream data widths, rounded up to whole bytes.
  localparam int IN_FIELDS_W   = HUE_BITS + 2 * SL_W;
  localparam int IN_TDATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W  = 3 * CH_W;
  localparam int OUT_TDATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Payload held after the first stage.
  typedef struct packed {
    logic [SL_W-1:0] light;
    logic [SL_W-1:0] sat;
    logic [MS_W-1:0] ls;
    logic [T_W-1:0]  t_r;
    logic [T_W-1:0]  t_g;
    logic [T_W-1:0]  t_b;
  } front_t;

  // Payload held after the second stage.
  typedef struct packed {
    logic [MS_W-1:0] m1s;
    logic [MS_W-1:0] ds;
    logic [T_W-1:0]  t_r;
    logic [T_W-1:0]  t_g;
    logic [T_W-1:0]  t_b;
  } mix_t;

  // Weight of (m2 - m1) for a position x on the hue circle, in units of 1/2^HUE_BITS.
  // Rising edge over the first sixth of a turn, plateau up to half a turn, falling
  // edge up to two thirds of a turn, zero after that.
  function automatic logic [T_W-1:0] ramp_weight(input logic [X_W-1:0] x);
    logic [X_W:0] x2;
    logic [X_W:0] fall;
    logic [T_W-1:0] w;
    x2   = {x, 1'b0};
    fall = (X_W+1)'(4 << HUE_BITS) - x2;
    if (x2 < (X_W+1)'(1 << HUE_BITS)) begin
      w = T_W'(x2);
    end else if (x2 < (X_W+1)'(3 << HUE_BITS)) begin
      w = T_W'(1 << HUE_BITS);
    end else if (x < X_W'(2 << HUE_BITS)) begin
      w = T_W'(fall);
    end else begin
      w = '0;
    end
    return w;
  endfunction

endpackage

/* src/hsl2rgb_front.sv */
// First pipeline stage of the HSL to RGB converter: clamps saturation and lightness,
// forms their product and the ramp weights of the three hue positions.
// Depends on hsl2rgb_pkg.
module hsl2rgb_front (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic [hsl2rgb_pkg::HUE_BITS-1:0]    hue_i,
  input  logic [hsl2rgb_pkg::SL_W-1:0]        sat_i,
  input  logic [hsl2rgb_pkg::SL_W-1:0]        light_i,
  output hsl2rgb_pkg::front_t                 front_o
);

  localparam logic [hsl2rgb_pkg::SL_W-1:0] One = hsl2rgb_pkg::SL_W'(1 << hsl2rgb_pkg::FRAC_BITS);
  localparam logic [hsl2rgb_pkg::X_W:0] Span = (hsl2rgb_pkg::X_W+1)'(3 << hsl2rgb_pkg::HUE_BITS);
  localparam logic [hsl2rgb_pkg::X_W:0] Third = (hsl2rgb_pkg::X_W+1)'(1 << hsl2rgb_pkg::HUE_BITS);

  logic [hsl2rgb_pkg::SL_W-1:0] sat_c;
  logic [hsl2rgb_pkg::SL_W-1:0] light_c;
  logic [2*hsl2rgb_pkg::SL_W-1:0] prod;
  logic [hsl2rgb_pkg::X_W:0] x_g;
  logic [hsl2rgb_pkg::X_W:0] x_r_raw;
  logic [hsl2rgb_pkg::X_W:0] x_b_raw;
  logic [hsl2rgb_pkg::X_W:0] x_r;
  logic [hsl2rgb_pkg::X_W:0] x_b;
  hsl2rgb_pkg::front_t front_d;
  hsl2rgb_pkg::front_t front_q;

  always_comb begin
    sat_c   = (sat_i > One) ? One : sat_i;
    light_c = (light_i > One) ? One : light_i;
    prod    = sat_c * light_c;

    // Green sits at the hue itself, red one third of a turn ahead, blue two thirds.
    x_g     = ({1'b0, hue_i, 1'b0}) + (hsl2rgb_pkg::X_W+1)'(hue_i);
    x_r_raw = x_g + Third;
    x_b_raw = x_g + {Third[hsl2rgb_pkg::X_W-1:0], 1'b0};
    x_r     = (x_r_raw >= Span) ? x_r_raw - Span : x_r_raw;
    x_b     = (x_b_raw >= Span) ? x_b_raw - Span : x_b_raw;

    front_d.light = light_c;
    front_d.sat   = sat_c;
    front_d.ls    = prod[hsl2rgb_pkg::MS_W-1:0];
    front_d.t_r   = hsl2rgb_pkg::ramp_weight(x_r[hsl2rgb_pkg::X_W-1:0]);
    front_d.t_g   = hsl2rgb_pkg::ramp_weight(x_g[hsl2rgb_pkg::X_W-1:0]);
    front_d.t_b   = hsl2rgb_pkg::ramp_weight(x_b[hsl2rgb_pkg::X_W-1:0]);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      front_q <= front_d;
    end
  end

  assign front_o = front_q;

endmodule

/* src/hsl2rgb_mix.sv */
// Second pipeline stage of the HSL to RGB converter: forms the intermediates m1 and
// m2 - m1 from lightness, saturation and their product.
// Depends on hsl2rgb_pkg.
module hsl2rgb_mix (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  hsl2rgb_pkg::front_t  front_i,
  output hsl2rgb_pkg::mix_t    mix_o
);

  localparam int W = hsl2rgb_pkg::MS_W + 1;
  localparam int F = hsl2rgb_pkg::FRAC_BITS;
  localparam logic [hsl2rgb_pkg::SL_W-1:0] Half = hsl2rgb_pkg::SL_W'(1 << (F - 1));

  logic [W-1:0] l_sc;
  logic [W-1:0] s_sc;
  logic [W-1:0] ls_w;
  logic [W-1:0] m2s;
  logic [W-1:0] m1s;
  logic [W-1:0] ds;
  hsl2rgb_pkg::mix_t mix_d;
  hsl2rgb_pkg::mix_t mix_q;

  always_comb begin
    l_sc = W'({front_i.light, {F{1'b0}}});
    s_sc = W'({front_i.sat, {F{1'b0}}});
    ls_w = W'(front_i.ls);
    if (front_i.light <= Half) begin
      m2s = l_sc + ls_w;
    end else begin
      m2s = l_sc + s_sc - ls_w;
    end
    m1s = {l_sc[W-2:0], 1'b0} - m2s;
    ds  = m2s - m1s;

    mix_d.m1s = m1s[hsl2rgb_pkg::MS_W-1:0];
    mix_d.ds  = ds[hsl2rgb_pkg::MS_W-1:0];
    mix_d.t_r = front_i.t_r;
    mix_d.t_g = front_i.t_g;
    mix_d.t_b = front_i.t_b;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mix_q <= mix_d;
    end
  end

  assign mix_o = mix_q;

endmodule

/* src/hsl2rgb_chan.sv */
// Third and fourth pipeline stages of the HSL to RGB converter for one channel:
// multiply-add of the ramp, then scale by 255, truncate and saturate.
// Depends on hsl2rgb_pkg.
module hsl2rgb_chan (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  logic [hsl2rgb_pkg::MS_W-1:0]       m1s_i,
  input  logic [hsl2rgb_pkg::MS_W-1:0]       ds_i,
  input  logic [hsl2rgb_pkg::T_W-1:0]        weight_i,
  output logic [hsl2rgb_pkg::CH_W-1:0]       chan_o
);

  localparam int PW = hsl2rgb_pkg::ACC_W + 8;
  localparam int VW = PW - hsl2rgb_pkg::OUT_SHIFT;

  logic [hsl2rgb_pkg::MS_W+hsl2rgb_pkg::T_W-1:0] mul;
  logic [hsl2rgb_pkg::ACC_W-1:0] acc_d;
  logic [hsl2rgb_pkg::ACC_W-1:0] acc_q;
  logic [PW-1:0] scaled;
  logic [VW-1:0] val;
  logic [hsl2rgb_pkg::CH_W-1:0] chan_d;
  logic [hsl2rgb_pkg::CH_W-1:0] chan_q;

  always_comb begin
    mul   = ds_i * weight_i;
    acc_d = hsl2rgb_pkg::ACC_W'({m1s_i, {hsl2rgb_pkg::HUE_BITS{1'b0}}})
          + mul[hsl2rgb_pkg::ACC_W-1:0];
  end

  // Times 255 is times 256 minus one copy.
  always_comb begin
    scaled = {acc_q, 8'h00} - PW'(acc_q);
    val    = scaled[PW-1:hsl2rgb_pkg::OUT_SHIFT];
    if (val > VW'(255)) begin
      chan_d = '1;
    end else begin
      chan_d = val[hsl2rgb_pkg::CH_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      acc_q  <= acc_d;
      chan_q <= chan_d;
    end
  end

  assign chan_o = chan_q;

endmodule

/* src/hsl_to_rgb_convert.sv */
// HSL to RGB pixel converter, top level with stream ports and pipeline control.
// Depends on hsl2rgb_pkg, hsl2rgb_front, hsl2rgb_mix and hsl2rgb_chan.
//
// This block converts one HSL pixel per beat into three RGB bytes. Hue is a 12-bit
// fraction of a full turn (4096 is 360 degrees); saturation and lightness are
// unsigned Q1.8 where 256 is 1.0, and values above 1.0 are clamped. Each channel is
// the standard piecewise hue ramp between m1 and m2, evaluated exactly at hue plus a
// third of a turn (red), hue (green) and hue minus a third of a turn (blue), then
// multiplied by 255, truncated and saturated. Zero saturation falls out of the same
// arithmetic as gray, lightness times 255 truncated. The datapath is a four-stage
// pipeline: clamp and the saturation-lightness product, the m1/m2 intermediates,
// one ramp multiply-add per channel, then the scale by 255. While the pipeline advances,
// a pixel is accepted every clock and each result leaves from the fourth stage, the output
// register. The whole pipeline advances together whenever the output register is
// empty or being taken, so a stall downstream holds every stage and drops nothing,
// and s_axis_tready_o follows m_axis_tready_i within the same cycle while a result
// is waiting.
module hsl_to_rgb_convert (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // Fields from bit 0 up: hue (12), saturation (9), lightness (9), zero fill (2).
  input  logic [hsl2rgb_pkg::IN_TDATA_W-1:0]   s_axis_tdata_i,
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  // Fields from bit 0 up: red (8), green (8), blue (8).
  output logic [hsl2rgb_pkg::OUT_TDATA_W-1:0]  m_axis_tdata_o
);

  localparam int H  = hsl2rgb_pkg::HUE_BITS;
  localparam int SW = hsl2rgb_pkg::SL_W;
  localparam int NSTAGE = 4;

  logic                      en;
  logic [NSTAGE-1:0]         vld_q;
  logic [H-1:0]              hue;
  logic [SW-1:0]             sat;
  logic [SW-1:0]             light;
  hsl2rgb_pkg::front_t       front;
  hsl2rgb_pkg::mix_t         mix;
  logic [hsl2rgb_pkg::CH_W-1:0] red;
  logic [hsl2rgb_pkg::CH_W-1:0] green;
  logic [hsl2rgb_pkg::CH_W-1:0] blue;

  // Unpack the input beat.
  assign hue   = s_axis_tdata_i[H-1:0];
  assign sat   = s_axis_tdata_i[H+SW-1:H];
  assign light = s_axis_tdata_i[H+2*SW-1:H+SW];

  // The pipeline moves as one whenever the output register can take a new value.
  assign en = ~vld_q[NSTAGE-1] | m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NSTAGE-2:0], s_axis_tvalid_i};
    end
  end

  hsl2rgb_front u_front (
    .clk_i   (clk_i),
    .en_i    (en),
    .hue_i   (hue),
    .sat_i   (sat),
    .light_i (light),
    .front_o (front)
  );

  hsl2rgb_mix u_mix (
    .clk_i   (clk_i),
    .en_i    (en),
    .front_i (front),
    .mix_o   (mix)
  );

  hsl2rgb_chan u_chan_r (
    .clk_i    (clk_i),
    .en_i     (en),
    .m1s_i    (mix.m1s),
    .ds_i     (mix.ds),
    .weight_i (mix.t_r),
    .chan_o   (red)
  );

  hsl2rgb_chan u_chan_g (
    .clk_i    (clk_i),
    .en_i     (en),
    .m1s_i    (mix.m1s),
    .ds_i     (mix.ds),
    .weight_i (mix.t_g),
    .chan_o   (green)
  );

  hsl2rgb_chan u_chan_b (
    .clk_i    (clk_i),
    .en_i     (en),
    .m1s_i    (mix.m1s),
    .ds_i     (mix.ds),
    .weight_i (mix.t_b),
    .chan_o   (blue)
  );

  assign s_axis_tready_o = en;
  assign m_axis_tvalid_o = vld_q[NSTAGE-1];
  assign m_axis_tdata_o  = hsl2rgb_pkg::OUT_TDATA_W'({blue, green, red});

`ifndef SYNTHESIS
  // A waiting result must freeze the input side.
  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |-> !s_axis_tready_o)
    else $error("input accepted while the output register is stalled");

  // With no result waiting, the block must always take a pixel.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input not ready although the output register is empty");

  // An accepted pixel must occupy the first stage on the next cycle.
  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> vld_q[0])
    else $error("accepted pixel missing from the first stage");
`endif

endmodule

/* test/tb.sv */
// Self-checking testbench for the HSL to RGB pixel converter hsl_to_rgb_convert.
// A scoreboard class predicts each RGB beat from the accepted HSL beat; plain tasks drive
// the stream ports. Depends on hsl2rgb_pkg and the RTL in src.

// Holds the RGB bytes expected for every accepted pixel, oldest first.
class rgb_scoreboard;
  localparam longint unsigned HUE_TURN = 64'd1 << hsl2rgb_pkg::HUE_BITS;
  localparam longint unsigned Q_ONE    = 64'd1 << hsl2rgb_pkg::FRAC_BITS;

  typedef struct {
    logic [hsl2rgb_pkg::CH_W-1:0] red;
    logic [hsl2rgb_pkg::CH_W-1:0] green;
    logic [hsl2rgb_pkg::CH_W-1:0] blue;
  } rgb_t;

  rgb_t        expected_rgb[$];
  int unsigned errors;

  function new();
    errors = 0;
  endfunction

  // One channel of the hue ramp. m1s and ds are in units of 1/Q_ONE^2, x is the
  // position on the hue circle in units of 1/(3*HUE_TURN) turn.
  function logic [7:0] ramp_level(longint unsigned m1s, longint unsigned ds,
                                  longint unsigned x);
    longint unsigned num;
    longint unsigned level;
    if (2 * x < HUE_TURN) begin
      num = m1s * HUE_TURN + ds * (2 * x);
    end else if (2 * x < 3 * HUE_TURN) begin
      num = (m1s + ds) * HUE_TURN;
    end else if (x < 2 * HUE_TURN) begin
      num = m1s * HUE_TURN + ds * (4 * HUE_TURN - 2 * x);
    end else begin
      num = m1s * HUE_TURN;
    end
    level = (num * 255) / (Q_ONE * Q_ONE * HUE_TURN);
    return (level > 255) ? 8'd255 : level[7:0];
  endfunction

  function rgb_t hsl_to_rgb(logic [hsl2rgb_pkg::HUE_BITS-1:0] hue,
                            logic [hsl2rgb_pkg::SL_W-1:0] sat_in,
                            logic [hsl2rgb_pkg::SL_W-1:0] light_in);
    longint unsigned sat;
    longint unsigned light;
    longint unsigned m1s;
    longint unsigned m2s;
    longint unsigned ds;
    longint unsigned x;
    longint unsigned gray;
    rgb_t            rgb;
    // Anything above 1.0 is clamped to 1.0.
    sat   = (sat_in > Q_ONE) ? Q_ONE : sat_in;
    light = (light_in > Q_ONE) ? Q_ONE : light_in;
    if (sat == 0) begin
      gray = (light * 255) >> hsl2rgb_pkg::FRAC_BITS;
      if (gray > 255) begin
        gray = 255;
      end
      rgb.red   = gray[7:0];
      rgb.green = gray[7:0];
      rgb.blue  = gray[7:0];
      return rgb;
    end
    if (2 * light <= Q_ONE) begin
      m2s = light * Q_ONE + light * sat;
    end else begin
      m2s = light * Q_ONE + sat * Q_ONE - light * sat;
    end
    m1s = 2 * light * Q_ONE - m2s;
    ds  = m2s - m1s;
    // Red sits a third of a turn ahead of green, blue a third behind.
    x         = 3 * hue;
    rgb.red   = ramp_level(m1s, ds, (x + HUE_TURN) % (3 * HUE_TURN));
    rgb.green = ramp_level(m1s, ds, x);
    rgb.blue  = ramp_level(m1s, ds, (x + 2 * HUE_TURN) % (3 * HUE_TURN));
    return rgb;
  endfunction

  function void note_pixel(logic [hsl2rgb_pkg::HUE_BITS-1:0] hue,
                           logic [hsl2rgb_pkg::SL_W-1:0] sat_in,
                           logic [hsl2rgb_pkg::SL_W-1:0] light_in);
    expected_rgb.push_back(hsl_to_rgb(hue, sat_in, light_in));
  endfunction

  function void check_rgb(logic [hsl2rgb_pkg::OUT_TDATA_W-1:0] beat);
    rgb_t want;
    if (expected_rgb.size() == 0) begin
      $display("%0t: result beat %h arrived with no pixel pending", $time, beat);
      errors++;
      return;
    end
    want = expected_rgb.pop_front();
    if (beat[7:0] !== want.red) begin
      $display("%0t: red mismatch, expected %0d, actual %0d", $time, want.red, beat[7:0]);
      errors++;
    end
    if (beat[15:8] !== want.green) begin
      $display("%0t: green mismatch, expected %0d, actual %0d", $time, want.green,
               beat[15:8]);
      errors++;
    end
    if (beat[23:16] !== want.blue) begin
      $display("%0t: blue mismatch, expected %0d, actual %0d", $time, want.blue,
               beat[23:16]);
      errors++;
    end
  endfunction

  function int unsigned pending();
    return expected_rgb.size();
  endfunction
endclass

module tb;
  import hsl2rgb_pkg::*;

  // Cycles without any accepted beat before the run is declared hung. The longest
  // correct gap is the output hold-off plus the passage through the pipeline.
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned HOLD_OFF    = 64;
  localparam int unsigned PHASE_ITEMS = 600;
  localparam int unsigned DRAIN_WAIT  = 16;

  logic                   clk_i           = 1'b0;
  logic                   rst_ni          = 1'b0;
  logic                   s_axis_tvalid_i = 1'b0;
  logic                   s_axis_tready_o;
  logic [IN_TDATA_W-1:0]  s_axis_tdata_i  = '0;
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;

  rgb_scoreboard pixels = new();

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_req      = 0;
  int unsigned hold_left     = 0;
  int unsigned quiet_cycles  = 0;

  hsl_to_rgb_convert u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  initial begin
    forever begin
      #10 clk_i = ~clk_i;
    end
  end

  // Offers one pixel, with random idle cycles first, and returns at the edge that takes it.
  task automatic send_pixel(input logic [HUE_BITS-1:0] hue, input logic [SL_W-1:0] sat,
                            input logic [SL_W-1:0] light);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= IN_TDATA_W'({light, sat, hue});
    @(posedge clk_i);
    while (!s_axis_tready_o) begin
      @(posedge clk_i);
    end
    pixels.note_pixel(hue, sat, light);
  endtask

  // Saturation or lightness: zero, exactly one, values above one that get clamped,
  // or anything in the legal range.
  function automatic logic [SL_W-1:0] pick_level();
    case ($urandom_range(9))
      0:       return '0;
      1:       return SL_W'(1 << FRAC_BITS);
      2:       return SL_W'($urandom_range((1 << SL_W) - 1, (1 << FRAC_BITS) + 1));
      default: return SL_W'($urandom_range(1 << FRAC_BITS, 0));
    endcase
  endfunction

  task automatic send_random_pixel();
    logic [SL_W-1:0] sat;
    logic [SL_W-1:0] light;
    sat   = pick_level();
    light = pick_level();
    send_pixel(HUE_BITS'($urandom_range((1 << HUE_BITS) - 1, 0)), sat, light);
  endtask

  // Stops offering pixels until every pending result has been taken.
  task automatic wait_for_drain();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (pixels.pending() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // Result side: check every accepted beat, then pick tready for the next edge. A
  // hold-off request keeps tready low for a counted stretch of cycles.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      pixels.check_rgb(m_axis_tdata_o);
    end
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: any beat on either side counts as progress.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no beat accepted for %0d cycles", $time, STALL_LIMIT);
      $display("tb: errors");
      $finish;
    end
  end

  initial begin
    int unsigned phase;
    int unsigned n;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed pixels: gray with zero saturation, the primaries and the edges of the
    // ramp around the third and sixth turn points, both lightness branches, clamping
    // of saturation and lightness above one, and all-ones fields.
    send_pixel(12'd0,    9'd0,   9'd0);
    send_pixel(12'd0,    9'd0,   9'd256);
    send_pixel(12'd0,    9'd0,   9'd511);
    send_pixel(12'd4095, 9'd0,   9'd128);
    send_pixel(12'd0,    9'd256, 9'd128);
    send_pixel(12'd682,  9'd256, 9'd128);
    send_pixel(12'd683,  9'd256, 9'd128);
    send_pixel(12'd1365, 9'd256, 9'd128);
    send_pixel(12'd1366, 9'd256, 9'd128);
    send_pixel(12'd2048, 9'd256, 9'd128);
    send_pixel(12'd2730, 9'd256, 9'd128);
    send_pixel(12'd2731, 9'd256, 9'd128);
    send_pixel(12'd3413, 9'd256, 9'd128);
    send_pixel(12'd4095, 9'd256, 9'd128);
    send_pixel(12'd0,    9'd511, 9'd128);
    send_pixel(12'd0,    9'd256, 9'd256);
    send_pixel(12'd0,    9'd256, 9'd511);
    send_pixel(12'd1000, 9'd256, 9'd0);
    send_pixel(12'd1000, 9'd128, 9'd127);
    send_pixel(12'd1000, 9'd128, 9'd129);
    send_pixel(12'd3000, 9'd1,   9'd1);
    send_pixel(12'd3000, 9'd257, 9'd255);
    send_pixel(12'd2000, 9'd255, 9'd256);
    send_pixel(12'd4095, 9'd511, 9'd511);
    wait_for_drain();

    // Random pixels in three idle patterns: sender idle 30 / receiver 71, then swapped,
    // then full rate on both sides.
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 30;
          recv_idle_pct = 71;
        end
        1: begin
          send_idle_pct = 71;
          recv_idle_pct = 30;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (n = 0; n < PHASE_ITEMS; n++) begin
        // At full rate, block the output for a while so the pipeline fills and
        // back-pressures the input, and later pause the input until all is out.
        if (phase == 2 && n == 0) begin
          hold_req = HOLD_OFF;
        end
        if (phase == 2 && n == PHASE_ITEMS / 2) begin
          wait_for_drain();
        end
        send_random_pixel();
      end
      wait_for_drain();
    end

    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (pixels.errors == 0 && pixels.pending() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end
endmodule

/* sim.f */
src/hsl2rgb_pkg.sv
src/hsl2rgb_front.sv
src/hsl2rgb_mix.sv
src/hsl2rgb_chan.sv
src/hsl_to_rgb_convert.sv
test/tb.sv
